[rtl/stftms_pkg.sv]
// ----------------------------------------------------------------------------
// stftms_pkg: shared types, constants and functions
// Beat types, the frame job passed from the front to the back, the back end
// sequencer states, and the cosine, window and bit-reverse helpers.
// ----------------------------------------------------------------------------
package stftms_pkg;

  localparam int FFT_SIZE_DEF = 64;
  localparam int OUT_DEPTH_DEF = 4;
  localparam int JOB_DEPTH = 2;

  localparam int SAMPLE_W = 16;
  localparam int HOP_W = 7;
  localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;
  localparam int FRAME_W = 16;
  localparam int BIN_W = 6;
  localparam int MAG_W = 17;
  localparam logic [MAG_W-1:0] MAG_MAX = 17'h1ffff;
  localparam int CNT_W = 7;   // sample count up to 64
  localparam int BASE_W = 6;  // ring address at the largest size
  localparam int VAL_W = 24;  // fixed-point FFT value
  localparam int COEF_W = 17; // Q15 cosine, 1.0 = 32768
  localparam int STG_W = 3;
  localparam int SQRT_STEPS = 26;
  localparam int IT_W = 5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio_sample;
    logic                       end_of_signal;
  } in_beat_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [BIN_W-1:0]   bin_number;
    logic [MAG_W-1:0]   bin_magnitude;
    logic               last_bin;
  } out_beat_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   count;
    logic [BASE_W-1:0]  base;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LD_RD,
    B_LD_MUL,
    B_LD_WR,
    B_BF_RD,
    B_BF_P0,
    B_BF_P1,
    B_BF_P2,
    B_BF_P3,
    B_BF_WA,
    B_BF_WB,
    B_MG_RD,
    B_MG_SQ0,
    B_MG_SQ1,
    B_MG_INIT,
    B_MG_SQRT
  } back_state_t;

  localparam logic signed [COEF_W-1:0] COS_Q [17] = '{
    17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
    17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
    17'sd12540, 17'sd9512,  17'sd6393,  17'sd3212,  17'sd0
  };

  // cos(2*pi*k/64) in Q15
  function automatic logic signed [COEF_W-1:0] cos64(input logic [5:0] k);
    logic signed [COEF_W-1:0] c;
    logic [5:0] t;
    t = 6'd0;
    if (k <= 6'd16) begin
      c = COS_Q[k[4:0]];
    end else if (k <= 6'd32) begin
      t = 6'd32 - k;
      c = -COS_Q[t[4:0]];
    end else if (k <= 6'd48) begin
      t = k - 6'd32;
      c = -COS_Q[t[4:0]];
    end else begin
      t = 6'd0 - k;
      c = COS_Q[t[4:0]];
    end
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] sin64(input logic [5:0] k);
    return cos64(k - 6'd16);
  endfunction

  // periodic Hann weight of point i for a frame of 2**lg points, 0 .. 32768
  function automatic logic [COEF_W-1:0] hann(input logic [5:0] i,
                                             input logic [STG_W-1:0] lg);
    logic signed [18:0] t;
    logic [5:0] k;
    k = i << (3'd6 - lg);
    t = 19'sd32769 - 19'(cos64(k));
    return COEF_W'(t >>> 1);
  endfunction

  function automatic logic [5:0] bitrev(input logic [5:0] i,
                                        input logic [STG_W-1:0] lg);
    logic [5:0] r;
    r = 6'd0;
    for (int b = 0; b < 6; b++) begin
      if (b < int'(lg)) r[b] = i[int'(lg) - 1 - b];
    end
    return r;
  endfunction

endpackage

[rtl/stftms_fifo.sv]
// ----------------------------------------------------------------------------
// stftms_fifo: small register queue
// Holds beats between two sides that stall on their own; power-of-two depth.
// ----------------------------------------------------------------------------
module stftms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? PW'((DEPTH == 1) ? 0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_rd ? PW'((DEPTH == 1) ? 0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

[rtl/stftms_front.sv]
// ----------------------------------------------------------------------------
// stftms_front: sample intake and frame triggering
// Writes samples into the ring, counts hops and raises a frame job for the
// back end; holds off new samples until the back end has loaded the frame.
// ----------------------------------------------------------------------------
module stftms_front #(
  parameter int FFT_SIZE = stftms_pkg::FFT_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  stftms_pkg::in_beat_t              in_data,
  input  logic                              cfg_we,
  input  logic [stftms_pkg::HOP_W-1:0]      cfg_wdata,
  output logic                              job_push,
  output stftms_pkg::job_t                  job,
  input  logic                              job_full,
  input  logic [$clog2(FFT_SIZE)-1:0]       ring_addr,
  output logic signed [stftms_pkg::SAMPLE_W-1:0] ring_q,
  input  logic                              load_done
);
  localparam int LG = $clog2(FFT_SIZE);
  localparam int SW = LG + 1;
  localparam int HW = stftms_pkg::HOP_W;

  logic signed [stftms_pkg::SAMPLE_W-1:0] ring_r [FFT_SIZE];
  logic [LG-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [SW-1:0] seen_r, seen_nxt;
  logic [HW-1:0] hop_cnt_r, hop_cnt_nxt, hop_len_r, hop_eff;
  logic [stftms_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic busy_r, busy_nxt;
  logic accept, filling, emit, short_frame;
  logic [SW-1:0] count;

  assign full    = busy_r || job_full;
  assign accept  = push && !full;
  assign hop_eff = (hop_len_r == '0) ? HW'(1) : hop_len_r;
  assign filling = (seen_r < SW'(FFT_SIZE));

  always_comb begin
    emit        = filling ? (seen_r + 1'b1 == SW'(FFT_SIZE)) : (hop_cnt_r == '0);
    short_frame = in_data.end_of_signal && !emit && filling;
    count       = emit ? SW'(FFT_SIZE) : SW'(seen_r + 1'b1);
    job_push    = accept && (emit || short_frame);
    job.frame   = frame_r;
    job.count   = stftms_pkg::CNT_W'(count);
    job.base    = stftms_pkg::BASE_W'(LG'(wr_ptr_r + 1'b1 - LG'(count)));

    wr_ptr_nxt  = wr_ptr_r;
    seen_nxt    = seen_r;
    hop_cnt_nxt = hop_cnt_r;
    frame_nxt   = frame_r;
    if (accept) begin
      wr_ptr_nxt = LG'(wr_ptr_r + 1'b1);
      if (filling) seen_nxt = SW'(seen_r + 1'b1);
      if (emit) begin
        hop_cnt_nxt = HW'(hop_eff - 1'b1);
        frame_nxt   = frame_r + 1'b1;
      end else if (!filling) begin
        hop_cnt_nxt = HW'(hop_cnt_r - 1'b1);
      end
      if (in_data.end_of_signal) begin
        seen_nxt    = '0;
        hop_cnt_nxt = '0;
        frame_nxt   = '0;
      end
    end
    busy_nxt = job_push ? 1'b1 : (load_done ? 1'b0 : busy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      seen_r    <= '0;
      hop_cnt_r <= '0;
      frame_r   <= '0;
      busy_r    <= 1'b0;
      hop_len_r <= stftms_pkg::HOP_RESET;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      seen_r    <= seen_nxt;
      hop_cnt_r <= hop_cnt_nxt;
      frame_r   <= frame_nxt;
      busy_r    <= busy_nxt;
      if (cfg_we) hop_len_r <= cfg_wdata;
    end
  end

  // sample ring: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept) ring_r[wr_ptr_r] <= in_data.audio_sample;
    ring_q <= ring_r[ring_addr];
  end

endmodule

[rtl/stftms_back.sv]
// ----------------------------------------------------------------------------
// stftms_back: windowing, FFT and magnitude sequencer
// Loads a windowed frame into the workspace in bit-reversed order, runs
// radix-2 butterflies over a shared multiplier, then takes bin magnitudes.
// ----------------------------------------------------------------------------
module stftms_back #(
  parameter int FFT_SIZE = stftms_pkg::FFT_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              job_empty,
  input  stftms_pkg::job_t                  job,
  output logic                              job_pop,
  output logic [$clog2(FFT_SIZE)-1:0]       ring_addr,
  input  logic signed [stftms_pkg::SAMPLE_W-1:0] ring_q,
  output logic                              load_done,
  input  logic                              res_full,
  output logic                              res_push,
  output stftms_pkg::out_beat_t             res
);
  localparam int LG = $clog2(FFT_SIZE);
  localparam int HALF = FFT_SIZE / 2;
  localparam int MW = LG - 1;
  localparam int VW = stftms_pkg::VAL_W;
  localparam int SGW = stftms_pkg::STG_W;

  stftms_pkg::back_state_t state_r, state_nxt;
  stftms_pkg::job_t job_r;
  logic [LG-1:0]  idx_r;
  logic [SGW-1:0] stage_r;
  logic [MW-1:0]  m_r;
  logic signed [33:0] prod_r;
  logic signed [41:0] acc_r;
  logic signed [VW-1:0] tr_r, ti_r;
  logic [2*VW-1:0] rda_r, rdb_r;
  logic [47:0] psq_r;
  logic [51:0] rad_r;
  logic [27:0] rem_r;
  logic [25:0] root_r;
  logic [stftms_pkg::IT_W-1:0] it_r;

  logic [2*VW-1:0] ws_r [FFT_SIZE];
  logic ws_we, rd_en;
  logic [LG-1:0] ws_wa, ws_ra, ws_rb;
  logic [2*VW-1:0] ws_wd;

  // butterfly addressing and twiddle
  logic [LG-1:0] mw, hmask, addr_a, addr_b, j;
  logic [5:0] tw_k;
  logic signed [stftms_pkg::COEF_W-1:0] tw_c, tw_s;
  always_comb begin
    mw     = LG'(m_r);
    hmask  = LG'((LG'(1) << stage_r) - 1'b1);
    j      = mw & hmask;
    addr_a = LG'(((mw >> stage_r) << (stage_r + 1'b1)) | j);
    addr_b = addr_a | LG'(LG'(1) << stage_r);
    tw_k   = 6'(6'(j) << (3'd5 - stage_r));
    tw_c   = stftms_pkg::cos64(tw_k);
    tw_s   = stftms_pkg::sin64(tw_k);
  end

  logic signed [VW-1:0] ar, ai, br, bi, ti_now, x_ld;
  logic signed [VW-1:0] mul_x;
  logic signed [stftms_pkg::COEF_W-1:0] mul_y;
  logic signed [40:0] mul_p;
  logic signed [VW-1:0] sq_x;
  logic signed [47:0] sq_p;
  logic signed [stftms_pkg::SAMPLE_W-1:0] smp;
  logic signed [33:0] ld_p;
  logic [stftms_pkg::COEF_W-1:0] win;
  logic [29:0] rem_sh, trial;
  logic [26:0] rsum;
  logic [26:0] mag_full;

  always_comb begin
    ar = rda_r[2*VW-1:VW];
    ai = rda_r[VW-1:0];
    br = rdb_r[2*VW-1:VW];
    bi = rdb_r[VW-1:0];
    case (state_r)
      stftms_pkg::B_BF_P0: begin mul_x = br; mul_y = tw_c; end
      stftms_pkg::B_BF_P1: begin mul_x = bi; mul_y = tw_s; end
      stftms_pkg::B_BF_P2: begin mul_x = bi; mul_y = tw_c; end
      default:             begin mul_x = br; mul_y = tw_s; end
    endcase
    mul_p  = mul_x * mul_y;
    ti_now = VW'((acc_r + 42'sd16384) >>> 15);
    x_ld   = VW'((prod_r + 34'sd16384) >>> 15);
    sq_x   = (state_r == stftms_pkg::B_MG_SQ0) ? ar : ai;
    sq_p   = sq_x * sq_x;
    smp    = (stftms_pkg::CNT_W'(idx_r) < job_r.count) ? ring_q : '0;
    win    = stftms_pkg::hann(6'(idx_r), SGW'(LG));
    ld_p   = smp * $signed({1'b0, win});
    rem_sh = {rem_r, rad_r[51:50]};
    trial  = {2'b00, root_r, 2'b01};
    rsum   = 27'(root_r) + 27'(HALF);
    mag_full = rsum >> LG;
  end

  assign ring_addr = LG'(job_r.base[LG-1:0] + idx_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stftms_pkg::B_IDLE:    if (!job_empty) state_nxt = stftms_pkg::B_LD_RD;
      stftms_pkg::B_LD_RD:   state_nxt = stftms_pkg::B_LD_MUL;
      stftms_pkg::B_LD_MUL:  state_nxt = stftms_pkg::B_LD_WR;
      stftms_pkg::B_LD_WR:
        state_nxt = (idx_r == LG'(FFT_SIZE - 1)) ? stftms_pkg::B_BF_RD : stftms_pkg::B_LD_RD;
      stftms_pkg::B_BF_RD:   state_nxt = stftms_pkg::B_BF_P0;
      stftms_pkg::B_BF_P0:   state_nxt = stftms_pkg::B_BF_P1;
      stftms_pkg::B_BF_P1:   state_nxt = stftms_pkg::B_BF_P2;
      stftms_pkg::B_BF_P2:   state_nxt = stftms_pkg::B_BF_P3;
      stftms_pkg::B_BF_P3:   state_nxt = stftms_pkg::B_BF_WA;
      stftms_pkg::B_BF_WA:   state_nxt = stftms_pkg::B_BF_WB;
      stftms_pkg::B_BF_WB:
        if (m_r == MW'(HALF - 1) && stage_r == SGW'(LG - 1)) state_nxt = stftms_pkg::B_MG_RD;
        else state_nxt = stftms_pkg::B_BF_RD;
      stftms_pkg::B_MG_RD:   state_nxt = stftms_pkg::B_MG_SQ0;
      stftms_pkg::B_MG_SQ0:  state_nxt = stftms_pkg::B_MG_SQ1;
      stftms_pkg::B_MG_SQ1:  state_nxt = stftms_pkg::B_MG_INIT;
      stftms_pkg::B_MG_INIT: state_nxt = stftms_pkg::B_MG_SQRT;
      stftms_pkg::B_MG_SQRT:
        if (it_r == stftms_pkg::IT_W'(stftms_pkg::SQRT_STEPS)) begin
          if (!res_full) begin
            state_nxt = (idx_r == LG'(HALF)) ? stftms_pkg::B_IDLE : stftms_pkg::B_MG_RD;
          end
        end
      default: state_nxt = stftms_pkg::B_IDLE;
    endcase
  end

  // strobes and memory port controls
  always_comb begin
    job_pop   = 1'b0;
    load_done = 1'b0;
    res_push  = 1'b0;
    ws_we     = 1'b0;
    ws_wa     = addr_a;
    ws_wd     = {VW'(ar + tr_r), VW'(ai + ti_now)};
    ws_ra     = addr_a;
    ws_rb     = addr_b;
    rd_en     = 1'b0;
    case (state_r)
      stftms_pkg::B_IDLE: job_pop = !job_empty;
      stftms_pkg::B_LD_WR: begin
        ws_we     = 1'b1;
        ws_wa     = LG'(stftms_pkg::bitrev(6'(idx_r), SGW'(LG)));
        ws_wd     = {x_ld, VW'(0)};
        load_done = (idx_r == LG'(FFT_SIZE - 1));
      end
      stftms_pkg::B_BF_RD: rd_en = 1'b1;
      stftms_pkg::B_BF_WA: ws_we = 1'b1;
      stftms_pkg::B_BF_WB: begin
        ws_we = 1'b1;
        ws_wa = addr_b;
        ws_wd = {VW'(ar - tr_r), VW'(ai - ti_r)};
      end
      stftms_pkg::B_MG_RD: begin
        rd_en = 1'b1;
        ws_ra = idx_r;
      end
      stftms_pkg::B_MG_SQRT:
        res_push = (it_r == stftms_pkg::IT_W'(stftms_pkg::SQRT_STEPS)) && !res_full;
      default: ;
    endcase
    res.frame_number  = job_r.frame;
    res.bin_number    = stftms_pkg::BIN_W'(idx_r);
    res.bin_magnitude = (mag_full > 27'(stftms_pkg::MAG_MAX)) ?
                        stftms_pkg::MAG_MAX : stftms_pkg::MAG_W'(mag_full);
    res.last_bin      = (idx_r == LG'(HALF));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= stftms_pkg::B_IDLE;
    else        state_r <= state_nxt;
  end

  // workspace: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (ws_we) ws_r[ws_wa] <= ws_wd;
    if (rd_en) begin
      rda_r <= ws_r[ws_ra];
      rdb_r <= ws_r[ws_rb];
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    case (state_r)
      stftms_pkg::B_IDLE: begin
        job_r <= job;
        idx_r <= '0;
      end
      stftms_pkg::B_LD_MUL: prod_r <= ld_p;
      stftms_pkg::B_LD_WR: begin
        idx_r   <= LG'(idx_r + 1'b1);
        stage_r <= '0;
        m_r     <= '0;
      end
      stftms_pkg::B_BF_P0: acc_r <= 42'(mul_p);
      stftms_pkg::B_BF_P1: acc_r <= acc_r + 42'(mul_p);
      stftms_pkg::B_BF_P2: begin
        tr_r  <= VW'((acc_r + 42'sd16384) >>> 15);
        acc_r <= 42'(mul_p);
      end
      stftms_pkg::B_BF_P3: acc_r <= acc_r - 42'(mul_p);
      stftms_pkg::B_BF_WA: ti_r <= ti_now;
      stftms_pkg::B_BF_WB: begin
        idx_r <= '0;
        if (m_r == MW'(HALF - 1)) begin
          m_r     <= '0;
          stage_r <= SGW'(stage_r + 1'b1);
        end else begin
          m_r <= MW'(m_r + 1'b1);
        end
      end
      stftms_pkg::B_MG_SQ0: psq_r <= 48'(sq_p);
      stftms_pkg::B_MG_SQ1: psq_r <= psq_r + 48'(sq_p);
      stftms_pkg::B_MG_INIT: begin
        rad_r  <= {psq_r, 4'b0000};
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= '0;
      end
      stftms_pkg::B_MG_SQRT: begin
        if (it_r != stftms_pkg::IT_W'(stftms_pkg::SQRT_STEPS)) begin
          rad_r <= {rad_r[49:0], 2'b00};
          it_r  <= stftms_pkg::IT_W'(it_r + 1'b1);
          if (rem_sh >= trial) begin
            rem_r  <= 28'(rem_sh - trial);
            root_r <= {root_r[24:0], 1'b1};
          end else begin
            rem_r  <= 28'(rem_sh);
            root_r <= {root_r[24:0], 1'b0};
          end
        end else if (!res_full) begin
          idx_r <= LG'(idx_r + 1'b1);
        end
      end
      default: ;
    endcase
  end

  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty) else $error("job taken from empty queue");
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.last_bin) |=> (state_r == stftms_pkg::B_IDLE))
    else $error("frame did not end on last bin");
  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stftms_pkg::B_BF_RD) |-> (stage_r < SGW'(LG)))
    else $error("butterfly stage out of range");

endmodule

[rtl/stft_magnitude_spectrogram.sv]
// ----------------------------------------------------------------------------
// stft_magnitude_spectrogram: streaming Hann-windowed STFT magnitudes
// Q1.15 samples in, FFT_SIZE/2+1 saturated Q2.15 bin magnitudes per frame out.
// ----------------------------------------------------------------------------
// When a sample completes a frame (or ends a signal shorter than one frame)
// the front raises a job and refuses further samples until the back end has
// copied the windowed frame out of the ring, reading, weighting and writing
// each sample in turn. The back end then runs the butterflies through its
// single shared multiplier and takes each bin magnitude with a one-bit-a-cycle
// square root. One further job may wait in the queue between the two parts
// while the back end works; results drain through a queue of OUT_DEPTH
// beats, and a stalled result side holds the back end. Write hop_length only
// while idle; a value of zero acts as one, and a new value takes effect at
// the next frame. The ring and the FFT workspace need no clearing after
// reset.
// ----------------------------------------------------------------------------
module stft_magnitude_spectrogram #(
  parameter int FFT_SIZE  = stftms_pkg::FFT_SIZE_DEF,
  parameter int OUT_DEPTH = stftms_pkg::OUT_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  stftms_pkg::in_beat_t         in_data,
  output logic                         empty,
  input  logic                         pop,
  output stftms_pkg::out_beat_t        out_data,
  input  logic                         cfg_we,
  input  logic [stftms_pkg::HOP_W-1:0] cfg_wdata
);
  localparam int LG = $clog2(FFT_SIZE);

  stftms_pkg::job_t job_in, job_out;
  stftms_pkg::out_beat_t res;
  logic job_push, job_full, job_pop, job_empty;
  logic [LG-1:0] ring_addr;
  logic signed [stftms_pkg::SAMPLE_W-1:0] ring_q;
  logic load_done, res_full, res_push;

  // front: take samples, spot frame ends
  stftms_front #(.FFT_SIZE(FFT_SIZE)) u_front (
    .clk, .rst_n, .push, .full, .in_data, .cfg_we, .cfg_wdata,
    .job_push, .job(job_in), .job_full, .ring_addr, .ring_q, .load_done
  );

  // hold pending frame jobs between the two sides
  stftms_fifo #(.WIDTH($bits(stftms_pkg::job_t)), .DEPTH(stftms_pkg::JOB_DEPTH)) u_job_q (
    .clk, .rst_n, .wr_en(job_push), .wr_data(job_in), .full(job_full),
    .rd_en(job_pop), .rd_data(job_out), .empty(job_empty)
  );

  // back: window, transform, magnitudes
  stftms_back #(.FFT_SIZE(FFT_SIZE)) u_back (
    .clk, .rst_n, .job_empty, .job(job_out), .job_pop, .ring_addr, .ring_q,
    .load_done, .res_full, .res_push, .res
  );

  // result beats wait here for the consumer
  stftms_fifo #(.WIDTH($bits(stftms_pkg::out_beat_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk, .rst_n, .wr_en(res_push), .wr_data(res), .full(res_full),
    .rd_en(pop), .rd_data(out_data), .empty
  );

endmodule
